/* rtl/core/fpd_pkg.sv */
// Shared types, constants and the rule table of the fuzzy PD controller.
// Depends on nothing; used by fpd_div and fuzzy_pd_controller.
package fpd_pkg;

  localparam int IN_WIDTH_DEF = 16;
  localparam int BRK_W        = 14;
  localparam int CFG_IDX_W    = 3;
  localparam int WGT_W        = 7;
  localparam int SEG_W        = 3;
  localparam int LAB_W        = 4;
  localparam int DRIVE_W      = 8;
  localparam int FULL_WEIGHT  = 100;
  localparam int LEVEL_STEP   = 15;

  localparam logic [CFG_IDX_W-1:0] REG_ERR_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_MID  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_HIGH = 3'd5;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [BRK_W-1:0] delta;
    logic [BRK_W-1:0] gap;
  } fuzz_t;

  localparam logic signed [LAB_W-1:0] RULE_TBL [7][7] = '{
    '{-4'sd6, -4'sd6, -4'sd6, -4'sd5, -4'sd5, -4'sd5, -4'sd4},
    '{-4'sd5, -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd2, -4'sd1},
    '{-4'sd4, -4'sd3, -4'sd2, -4'sd1,  4'sd0,  4'sd1,  4'sd2},
    '{-4'sd4, -4'sd3, -4'sd1,  4'sd0,  4'sd1,  4'sd3,  4'sd4},
    '{-4'sd2, -4'sd1,  4'sd0,  4'sd1,  4'sd2,  4'sd3,  4'sd4},
    '{ 4'sd1,  4'sd2,  4'sd2,  4'sd3,  4'sd4,  4'sd4,  4'sd5},
    '{ 4'sd4,  4'sd5,  4'sd5,  4'sd5,  4'sd6,  4'sd6,  4'sd6}
  };

  localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  function automatic logic signed [LAB_W-1:0] rule_label(logic [2:0] row, logic [2:0] col);
    return RULE_TBL[row][col];
  endfunction

endpackage

/* rtl/core/fpd_div.sv */
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on fpd_pkg for default widths; carries a tag alongside the data.
module fpd_div #(
  parameter int NUM_W = fpd_pkg::BRK_W + fpd_pkg::WGT_W,
  parameter int DEN_W = fpd_pkg::BRK_W,
  parameter int Q_W   = fpd_pkg::WGT_W,
  parameter int TAG_W = fpd_pkg::SEG_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo,
  output logic [TAG_W-1:0] out_tag
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [Q_W-1:0]   v_r;
  logic [CW-1:0]    rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [TAG_W-1:0] tag_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic             pv;
    logic [CW-1:0]    prem;
    logic [DEN_W-1:0] pden;
    logic [Q_W-1:0]   pq;
    logic [TAG_W-1:0] ptag;
    logic [CW-1:0]    trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign pv   = in_valid;
      assign prem = CW'(in_num);
      assign pden = in_den;
      assign pq   = '0;
      assign ptag = in_tag;
    end else begin : g_next
      assign pv   = v_r[i-1];
      assign prem = rem_r[i-1];
      assign pden = den_r[i-1];
      assign pq   = q_r[i-1];
      assign ptag = tag_r[i-1];
    end

    assign trial = CW'(pden) << (Q_W - 1 - i);
    assign ge    = (prem >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? (prem - trial) : prem;
      den_r[i] <= pden;
      q_r[i]   <= {pq[Q_W-2:0], ge};
      tag_r[i] <= ptag;
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign out_quo   = q_r[Q_W-1];
  assign out_tag   = tag_r[Q_W-1];

endmodule

/* rtl/core/fuzzy_pd_controller.sv */
// Top level of the fuzzy PD controller: fuzzification, rule table, defuzzification.
// Depends on fpd_pkg and fpd_div.
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+---------------------------
//   input    | in_err, in_err_rate                 | start high, busy low
//   result   | out_drive                           | out_valid strobe, one cycle
//   config   | cfg_index, cfg_data                 | cfg_we high
//
// One transaction may enter every cycle. It passes two 7-stage divider pipelines
// (error and rate dividers in parallel, then the output divider) and four stages.
// Reset is synchronous; busy is high only while reset is asserted.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module fuzzy_pd_controller #(
  parameter int IN_WIDTH = fpd_pkg::IN_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [IN_WIDTH-1:0]    in_err,
  input  logic signed [IN_WIDTH-1:0]    in_err_rate,
  output logic                          out_valid,
  output logic signed [fpd_pkg::DRIVE_W-1:0] out_drive,
  input  logic                          cfg_we,
  input  logic [fpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpd_pkg::BRK_W-1:0]     cfg_data
);

  localparam int XW    = ((IN_WIDTH > fpd_pkg::BRK_W + 1) ? IN_WIDTH : fpd_pkg::BRK_W + 1) + 1;
  localparam int BW    = fpd_pkg::BRK_W;
  localparam int WW    = fpd_pkg::WGT_W;
  localparam int NUM_W = BW + WW;
  localparam int DN_W  = 16;
  localparam int DD_W  = 9;
  localparam int SUM_W = 18;
  localparam int LAT   = 18;

  logic [11:0] eb1_r, rb1_r;
  logic [12:0] eb2_r, rb2_r;
  logic [13:0] eb3_r, rb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eb1_r <= 12'd12;
      eb2_r <= 13'd24;
      eb3_r <= 14'd48;
      rb1_r <= 12'd16;
      rb2_r <= 13'd32;
      rb3_r <= 14'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpd_pkg::REG_ERR_LOW:   eb1_r <= cfg_data[11:0];
        fpd_pkg::REG_ERR_MID:   eb2_r <= cfg_data[12:0];
        fpd_pkg::REG_ERR_HIGH:  eb3_r <= cfg_data;
        fpd_pkg::REG_RATE_LOW:  rb1_r <= cfg_data[11:0];
        fpd_pkg::REG_RATE_MID:  rb2_r <= cfg_data[12:0];
        fpd_pkg::REG_RATE_HIGH: rb3_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = ~rst_n;

  function automatic fpd_pkg::fuzz_t fuzzify(logic signed [XW-1:0] x, logic [11:0] b1i,
                                             logic [12:0] b2i, logic [13:0] b3i);
    fpd_pkg::fuzz_t        res;
    logic signed [XW-1:0] b1, b2, b3, d, g;
    b1 = $signed(XW'(b1i));
    b2 = $signed(XW'(b2i));
    b3 = $signed(XW'(b3i));
    d  = '0;
    g  = XW'(1);
    res.seg = 3'd5;
    if (x > -b3 && x < b3) begin
      if (x <= -b2) begin
        res.seg = 3'd0; d = -b2 - x; g = b3 - b2;
      end else if (x <= -b1) begin
        res.seg = 3'd1; d = -b1 - x; g = b2 - b1;
      end else if (x <= 0) begin
        res.seg = 3'd2; d = -x; g = b1;
      end else if (x <= b1) begin
        res.seg = 3'd3; d = b1 - x; g = b1;
      end else if (x <= b2) begin
        res.seg = 3'd4; d = b2 - x; g = b2 - b1;
      end else begin
        res.seg = 3'd5; d = b3 - x; g = b3 - b2;
      end
    end else if (x <= -b3) begin
      res.seg = 3'd0; d = XW'(1); g = XW'(1);
    end
    res.delta = d[BW-1:0];
    res.gap   = g[BW-1:0];
    return res;
  endfunction

  // Stage A: segment choice and distance/gap for both inputs.
  logic           a_v_r;
  fpd_pkg::fuzz_t a_e_r, a_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    a_e_r <= fuzzify(XW'(in_err), eb1_r, eb2_r, eb3_r);
    a_d_r <= fuzzify(XW'(in_err_rate), rb1_r, rb2_r, rb3_r);
  end

  logic [NUM_W-1:0] num_e, num_d;
  assign num_e = NUM_W'(a_e_r.delta) * NUM_W'(fpd_pkg::FULL_WEIGHT);
  assign num_d = NUM_W'(a_d_r.delta) * NUM_W'(fpd_pkg::FULL_WEIGHT);

  logic             we_v, wd_v;
  logic [WW-1:0]    we_q, wd_q;
  logic [2:0]       we_seg, wd_seg;

  fpd_div #(.NUM_W(NUM_W), .DEN_W(BW), .Q_W(WW), .TAG_W(fpd_pkg::SEG_W)) u_div_err (
    .clk(clk), .rst_n(rst_n), .in_valid(a_v_r), .in_num(num_e), .in_den(a_e_r.gap),
    .in_tag(a_e_r.seg), .out_valid(we_v), .out_quo(we_q), .out_tag(we_seg)
  );

  fpd_div #(.NUM_W(NUM_W), .DEN_W(BW), .Q_W(WW), .TAG_W(fpd_pkg::SEG_W)) u_div_rate (
    .clk(clk), .rst_n(rst_n), .in_valid(a_v_r), .in_num(num_d), .in_den(a_d_r.gap),
    .in_tag(a_d_r.seg), .out_valid(wd_v), .out_quo(wd_q), .out_tag(wd_seg)
  );

  // Stage B: rule labels, weights and removal of duplicate labels.
  logic                                b_v_r;
  logic signed [fpd_pkg::LAB_W-1:0]    b_lab_r [4];
  logic [WW-1:0]                       b_wt_r  [4];
  logic signed [fpd_pkg::LAB_W-1:0]    lab_nxt [4];
  logic [WW-1:0]                       wt_nxt  [4];

  always_comb begin
    logic [WW-1:0] pw, dw, pc, dc;
    logic [1:0]    pa, pb;
    pw = we_q;
    dw = wd_q;
    pc = WW'(fpd_pkg::FULL_WEIGHT) - pw;
    dc = WW'(fpd_pkg::FULL_WEIGHT) - dw;
    lab_nxt[0] = fpd_pkg::rule_label(we_seg, wd_seg);
    lab_nxt[1] = fpd_pkg::rule_label(we_seg + 3'd1, wd_seg);
    lab_nxt[2] = fpd_pkg::rule_label(we_seg, wd_seg + 3'd1);
    lab_nxt[3] = fpd_pkg::rule_label(we_seg + 3'd1, wd_seg + 3'd1);
    wt_nxt[0] = (pw <= dw) ? pw : dw;
    wt_nxt[1] = (pc <= dw) ? pc : dw;
    wt_nxt[2] = (pw <= dc) ? pw : dc;
    wt_nxt[3] = (pc <= dc) ? pc : dc;
    for (int p = 0; p < 6; p++) begin
      pa = fpd_pkg::PAIR_A[p];
      pb = fpd_pkg::PAIR_B[p];
      if (lab_nxt[pa] == lab_nxt[pb]) begin
        if (wt_nxt[pa] > wt_nxt[pb]) begin
          wt_nxt[pb] = '0;
        end else begin
          wt_nxt[pa] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= we_v & wd_v;
    end
  end

  always_ff @(posedge clk) begin
    b_lab_r <= lab_nxt;
    b_wt_r  <= wt_nxt;
  end

  // Stage C: weighted sums, split into sign and magnitude.
  logic              c_v_r, c_neg_r;
  logic [DN_W-1:0]   c_mag_r;
  logic [DD_W-1:0]   c_den_r;
  logic signed [SUM_W-1:0] num_sum;
  logic [DD_W-1:0]   den_sum;

  always_comb begin
    logic signed [7:0]  lvl;
    logic signed [15:0] prod;
    num_sum = '0;
    den_sum = '0;
    for (int j = 0; j < 4; j++) begin
      lvl  = 8'(b_lab_r[j]) * 8'sd15;
      prod = 16'(lvl) * $signed(16'(b_wt_r[j]));
      num_sum = num_sum + SUM_W'(prod);
      den_sum = den_sum + DD_W'(b_wt_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] mag;
    mag = num_sum[SUM_W-1] ? -num_sum : num_sum;
    c_mag_r <= mag[DN_W-1:0];
    c_neg_r <= num_sum[SUM_W-1];
    c_den_r <= den_sum;
  end

  logic          q_v;
  logic [WW-1:0] q_quo;
  logic [1:0]    q_tag;

  fpd_div #(.NUM_W(DN_W), .DEN_W(DD_W), .Q_W(WW), .TAG_W(2)) u_div_out (
    .clk(clk), .rst_n(rst_n), .in_valid(c_v_r), .in_num(c_mag_r), .in_den(c_den_r),
    .in_tag({c_neg_r, c_den_r == '0}), .out_valid(q_v), .out_quo(q_quo), .out_tag(q_tag)
  );

  logic                              out_valid_r;
  logic signed [fpd_pkg::DRIVE_W-1:0] out_drive_r, drive_nxt;

  always_comb begin
    if (q_tag[0]) begin
      drive_nxt = '0;
    end else if (q_tag[1]) begin
      drive_nxt = -$signed(fpd_pkg::DRIVE_W'(q_quo));
    end else begin
      drive_nxt = $signed(fpd_pkg::DRIVE_W'(q_quo));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    out_drive_r <= drive_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start & ~busy, LAT))
    else $error("result strobe does not follow an accepted transaction");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive <= 8'sd90 && out_drive >= -8'sd90))
    else $error("drive out of range");

  a_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (we_v && wd_v) |-> (we_q <= WW'(fpd_pkg::FULL_WEIGHT) && wd_q <= WW'(fpd_pkg::FULL_WEIGHT)))
    else $error("membership weight above full scale");

endmodule
